### hw/rtl/mcit_pkg.sv
// Package for the multi-channel interval timer: action and status codes, item types.
// Used by every file in hw/rtl except mcit_divider.
package mcit_pkg;
	localparam int ChannelsDefault = 8;
	localparam int MaxReports = 8;
	localparam int QueueDepth = 2;

	localparam logic [2:0] ACT_TICK   = 3'd0;
	localparam logic [2:0] ACT_CONFIG = 3'd1;
	localparam logic [2:0] ACT_START  = 3'd2;
	localparam logic [2:0] ACT_STOP   = 3'd3;
	localparam logic [2:0] ACT_PERIOD = 3'd4;
	localparam logic [2:0] ACT_QUERY  = 3'd5;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_BAD_CHANNEL = 3'd1;
	localparam logic [2:0] ST_BAD_PERIOD  = 3'd2;
	localparam logic [2:0] ST_RUNNING     = 3'd3;
	localparam logic [2:0] ST_NOT_RUNNING = 3'd4;

	typedef struct packed {
		logic [2:0]  action;
		logic [2:0]  channel;
		logic [31:0] period_value;
		logic        repeat_mode;
		logic [63:0] now_us;
	} cmd_t;

	typedef struct packed {
		logic        kind;
		logic [2:0]  source_channel;
		logic [2:0]  status;
		logic [31:0] expiry_count;
		logic [31:0] remaining;
		logic        last;
	} res_t;
endpackage

### hw/rtl/mcit_cmd_if.sv
// Valid/ready channel interface for command items.
// Depends on mcit_pkg.
interface mcit_cmd_if import mcit_pkg::*; (input logic clk);
	logic valid;
	logic ready;
	cmd_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/mcit_res_if.sv
// Valid/ready channel interface for result items.
// Depends on mcit_pkg.
interface mcit_res_if import mcit_pkg::*; (input logic clk);
	logic valid;
	logic ready;
	res_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/mcit_front.sv
// Front end: accepts items, drops undefined actions, queues the rest.
// Depends on mcit_pkg.
module mcit_front import mcit_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  cmd_t in_item,
	output logic q_valid,
	input  logic q_ready,
	output cmd_t q_item
);
	localparam int PW = $clog2(QueueDepth);
	cmd_t            mem_q [QueueDepth];
	logic [PW-1:0]   wp_q, rp_q;
	logic [PW:0]     cnt_q;
	logic            push, pop;

	assign in_ready = (cnt_q != (PW+1)'(QueueDepth));
	// undefined actions are taken and dropped here
	assign push = in_valid && in_ready && (in_item.action <= ACT_QUERY);
	assign q_valid = (cnt_q != '0);
	assign pop = q_valid && q_ready;
	assign q_item = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == (PW+1)'(QueueDepth) |-> !push) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> !pop) else $error("queue underflow");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count slip");
`endif
endmodule

### hw/rtl/mcit_divider.sv
// Serial restoring divider: 64-bit dividend by 32-bit divisor, one bit per cycle.
// Standalone; used by the back end for elapsed/period.
module mcit_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [63:0] quotient
);
	logic [63:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] dvs_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [32:0] trial;
	logic [32:0] shifted;

	assign shifted = {rem_q, quo_q[63]};
	assign trial = shifted - {1'b0, dvs_q};
	assign quotient = quo_q;

	// the partial remainder stays below the divisor, so 32 bits hold it
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend; rem_q <= '0; dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0]; quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted[31:0]; quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0; cnt_q <= '0; done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1; cnt_q <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0; done <= 1'b1;
				end
			end
		end
	end
endmodule

### hw/rtl/mcit_back.sv
// Back end: channel state, command execution and the tick scan with a serial divider.
// Depends on mcit_pkg and mcit_divider.
module mcit_back import mcit_pkg::*; #(
	parameter int CHANNELS = ChannelsDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	output logic q_ready,
	input  cmd_t q_item,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_item
);
	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_DIV = 3'd2, S_MUL = 3'd3,
		S_ADD = 3'd4, S_EMIT = 3'd5, S_FLUSH = 3'd6;

	logic [31:0] period_q [CHANNELS];
	logic [63:0] start_q [CHANNELS];
	logic [CHANNELS-1:0] run_q, rep_q, cfg_q;

	logic [2:0]  state_q;
	cmd_t        cmd_q;
	logic [CW:0] idx_q;
	logic [3:0]  nout_q;
	logic [CW-1:0] ci;
	logic [31:0] cnt_q;
	logic [63:0] prod_q;
	res_t        pend_q;
	logic        pend_v_q;
	logic        pend_load;
	logic        div_start, div_done;
	logic [63:0] quo;
	logic [63:0] elapsed;
	logic [CW-1:0] cch;
	logic        ch_ok;
	res_t        reply;

	assign ci = idx_q[CW-1:0];
	assign cch = CW'(q_item.channel);
	assign ch_ok = ({29'd0, q_item.channel} < 32'(CHANNELS));
	assign elapsed = cmd_q.now_us - start_q[ci];
	assign div_start = (state_q == S_SCAN) && (idx_q < (CW+1)'(CHANNELS)) &&
		(nout_q < 4'(MaxReports)) && cfg_q[ci] && run_q[ci] && (period_q[ci] != '0);

	mcit_divider u_div (.clk, .arst_n, .start(div_start), .dividend(elapsed),
		.divisor(period_q[ci]), .done(div_done), .quotient(quo));

	// reply to a command, from current state
	always_comb begin
		logic [63:0] el;
		el = q_item.now_us - start_q[cch];
		reply = '0;
		reply.source_channel = q_item.channel;
		reply.last = 1'b1;
		reply.status = ST_OK;
		if (!ch_ok) reply.status = ST_BAD_CHANNEL;
		else if (q_item.action == ACT_CONFIG) begin
			if (q_item.period_value == '0) reply.status = ST_BAD_PERIOD;
		end else if (!cfg_q[cch]) reply.status = ST_BAD_CHANNEL;
		else begin
			unique case (q_item.action)
				ACT_START: if (run_q[cch]) reply.status = ST_RUNNING;
				ACT_STOP: if (!run_q[cch]) reply.status = ST_NOT_RUNNING;
				ACT_PERIOD: if (q_item.period_value == '0) reply.status = ST_BAD_PERIOD;
				ACT_QUERY: begin
					if (!run_q[cch]) reply.status = ST_NOT_RUNNING;
					else if (el < {32'd0, period_q[cch]}) reply.remaining = period_q[cch] - el[31:0];
				end
				default: ;
			endcase
		end
	end

	assign q_ready = (state_q == S_IDLE) && !(out_valid && !out_ready);
	// a tick report is offered only once the next one replaces it or the scan marks it last
	assign out_valid = pend_v_q && (pend_q.last || state_q == S_EMIT);
	assign out_item = pend_q;
	assign pend_load = ((state_q == S_IDLE) && q_valid && q_ready && (q_item.action != ACT_TICK)) ||
		((state_q == S_EMIT) && (!pend_v_q || out_ready));

	always_ff @(posedge clk) begin
		if (div_done) cnt_q <= (quo[63:32] != '0) ? 32'hFFFF_FFFF : quo[31:0];
		if (state_q == S_MUL) prod_q <= {32'd0, cnt_q} * {32'd0, period_q[ci]};
		if (q_valid && q_ready) cmd_q <= q_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; idx_q <= '0; nout_q <= '0; pend_v_q <= 1'b0; pend_q <= '0;
			run_q <= '0; rep_q <= '0; cfg_q <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				period_q[i] <= '0; start_q[i] <= '0;
			end
		end else begin
			if (out_valid && out_ready && !pend_load) pend_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (q_valid && q_ready) begin
					if (q_item.action == ACT_TICK) begin
						state_q <= S_SCAN; idx_q <= '0; nout_q <= '0;
					end else begin
						pend_q <= reply; pend_v_q <= 1'b1;
						if (reply.status == ST_OK) begin
							unique case (q_item.action)
								ACT_CONFIG: begin
									period_q[cch] <= q_item.period_value;
									rep_q[cch] <= q_item.repeat_mode;
									start_q[cch] <= '0; run_q[cch] <= 1'b0;
									cfg_q[cch] <= 1'b1;
								end
								ACT_START: begin
									start_q[cch] <= q_item.now_us; run_q[cch] <= 1'b1;
								end
								ACT_STOP: run_q[cch] <= 1'b0;
								ACT_PERIOD: begin
									period_q[cch] <= q_item.period_value;
									if (run_q[cch]) start_q[cch] <= q_item.now_us;
								end
								default: ;
							endcase
						end
					end
				end
				S_SCAN: begin
					if (idx_q >= (CW+1)'(CHANNELS) || nout_q >= 4'(MaxReports)) begin
						state_q <= S_FLUSH;
					end else if (div_start) state_q <= S_DIV;
					else idx_q <= idx_q + 1'b1;
				end
				S_DIV: if (div_done) state_q <= (quo == '0) ? S_ADD : S_MUL;
				S_MUL: state_q <= S_ADD;
				S_ADD: begin
					if (cnt_q == '0) begin
						idx_q <= idx_q + 1'b1; state_q <= S_SCAN;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: if (!pend_v_q || out_ready) begin
					// hold the new report back until we know whether it is last
					pend_q.kind <= 1'b1; pend_q.source_channel <= 3'(ci);
					pend_q.status <= ST_OK; pend_q.expiry_count <= cnt_q;
					pend_q.remaining <= '0; pend_q.last <= 1'b0;
					pend_v_q <= 1'b1;
					start_q[ci] <= start_q[ci] + prod_q;
					if (!rep_q[ci]) run_q[ci] <= 1'b0;
					nout_q <= nout_q + 1'b1; idx_q <= idx_q + 1'b1;
					state_q <= S_SCAN;
				end
				S_FLUSH: begin
					// mark the held report as the last one of this tick
					if (pend_v_q) pend_q.last <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item)) else $error("result dropped");
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && q_ready |-> state_q == S_IDLE) else $error("accept while busy");
	a_report_limit: assert property (@(posedge clk) disable iff (!arst_n)
		nout_q <= 4'(MaxReports)) else $error("too many reports");
`endif
endmodule

### hw/rtl/multi_channel_interval_timer.sv
// Multi-channel interval timer top level: front queue plus back-end executor.
// Commands pass through the front queue and the registered result; one command per cycle
// while no tick runs and the output does not stall. Tick: the scan visits each channel;
// a running one takes a serial divide and an add, plus a multiply and an emit if it reports.
// Asynchronous active-low reset clears all channel state and the queue.
module multi_channel_interval_timer import mcit_pkg::*; #(
	parameter int CHANNELS = ChannelsDefault
) (
	input logic clk,
	input logic arst_n,
	mcit_cmd_if.sink in,
	mcit_res_if.source out
);
	logic q_valid, q_ready;
	cmd_t q_item;

	mcit_front u_front (.clk, .arst_n, .in_valid(in.valid), .in_ready(in.ready),
		.in_item(in.payload), .q_valid, .q_ready, .q_item);
	mcit_back #(.CHANNELS(CHANNELS)) u_back (.clk, .arst_n, .q_valid, .q_ready, .q_item,
		.out_valid(out.valid), .out_ready(out.ready), .out_item(out.payload));
endmodule
